// ===== hdl/mscs_pkg.sv =====
// Shared types, constants and segment tables for the contour stream block.
// No dependencies; imported by every module under hdl.
package mscs_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int CNT_W       = (COL_W + 1 > 11) ? COL_W + 1 : 11;
   localparam int COORD_W     = 15;
   localparam int SIZE_W      = 5;

   localparam logic signed [15:0] LEVEL_RESET = 16'sd4915;
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 5'd2;
   localparam logic [10:0]        COLS_RESET  = 11'd1024;

   typedef enum logic [1:0] {
      CSR_LEVEL   = 2'd0,
      CSR_SIZE    = 2'd1,
      CSR_COLUMNS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PT_TOP    = 2'd0,
      PT_BOTTOM = 2'd1,
      PT_LEFT   = 2'd2,
      PT_RIGHT  = 2'd3
   } pt_type;

   typedef struct packed {
      pt_type a;
      pt_type b;
   } seg_pts_type;

   // one sample on its way from the front end to the segment stage
   typedef struct packed {
      logic                emit;
      logic                cur;
      logic                left;
      logic [COORD_W-1:0]  x_base;
      logic [COORD_W-1:0]  y_base;
      logic [SIZE_W-1:0]   size;
   } cell_type;

   function automatic logic [1:0] seg_count(input logic [3:0] idx);
      logic [1:0] n;
      unique case (idx)
         4'd0, 4'd15: n = 2'd0;
         4'd5, 4'd10: n = 2'd2;
         default:     n = 2'd1;
      endcase
      return n;
   endfunction

   function automatic seg_pts_type seg_pts(input logic [3:0] idx, input logic sel);
      seg_pts_type p;
      unique case (idx)
         4'd1, 4'd14: p = '{PT_LEFT,  PT_BOTTOM};
         4'd2, 4'd13: p = '{PT_RIGHT, PT_BOTTOM};
         4'd3, 4'd12: p = '{PT_LEFT,  PT_RIGHT};
         4'd4, 4'd11: p = '{PT_TOP,   PT_RIGHT};
         4'd6, 4'd9:  p = '{PT_TOP,   PT_BOTTOM};
         4'd7, 4'd8:  p = '{PT_TOP,   PT_LEFT};
         4'd5:        p = sel ? seg_pts_type'{PT_RIGHT, PT_BOTTOM}
                              : seg_pts_type'{PT_TOP, PT_LEFT};
         4'd10:       p = sel ? seg_pts_type'{PT_LEFT, PT_BOTTOM}
                              : seg_pts_type'{PT_TOP, PT_RIGHT};
         default:     p = '{PT_TOP, PT_TOP};
      endcase
      return p;
   endfunction

   // midpoint of a cell edge, returned as {x, y}
   function automatic logic [2*COORD_W-1:0] point_of(input pt_type p,
                                                     input logic [COORD_W-1:0] xb,
                                                     input logic [COORD_W-1:0] yb,
                                                     input logic [SIZE_W-1:0] s);
      logic [COORD_W-1:0] h;
      logic [COORD_W-1:0] sz;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      h  = COORD_W'(s >> 1);
      sz = COORD_W'(s);
      unique case (p)
         PT_TOP:    begin px = xb + h;  py = yb;      end
         PT_BOTTOM: begin px = xb + h;  py = yb + sz; end
         PT_LEFT:   begin px = xb;      py = yb + h;  end
         default:   begin px = xb + sz; py = yb + h;  end
      endcase
      return {px, py};
   endfunction

endpackage

// ===== hdl/mscs_line_buf.sv =====
// Line buffer: one threshold bit per column of the row above.
// Depends on mscs_pkg. Read-before-write on the same address, registered read.
module mscs_line_buf
   import mscs_pkg::*;
(
   input  logic             clock,
   input  logic             access,
   input  logic [COL_W-1:0] addr,
   input  logic             wr_bit,
   output logic             rd_bit_ff
);

   logic mem [MAX_COLUMNS];

   // old contents come out, new bit goes in, same edge
   always_ff @(posedge clock) begin
      if (access) begin
         rd_bit_ff  <= mem[addr];
         mem[addr]  <= wr_bit;
      end
   end

endmodule

// ===== hdl/mscs_seg_emit.sv =====
// Segment stage: forms the case index and sends out up to two segments.
// Depends on mscs_pkg; fed by the front end and by mscs_line_buf.
module mscs_seg_emit
   import mscs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  cell_type           grid_cell,
   input  logic               above,
   output logic               ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COORD_W-1:0] rsp_x_start,
   output logic [COORD_W-1:0] rsp_y_start,
   output logic [COORD_W-1:0] rsp_x_end,
   output logic [COORD_W-1:0] rsp_y_end,
   output logic               rsp_last
);

   logic               s1_valid_ff, s1_valid_in;
   cell_type           s1_ff;
   logic               seg_sel_ff, seg_sel_in;
   logic               above_left_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] xs_ff, ys_ff, xe_ff, ye_ff;
   logic               last_ff;

   logic [3:0]           idx;
   logic [1:0]           n;
   logic                 out_free, seg_fire, last_seg, s1_done;
   seg_pts_type          pts;
   logic [2*COORD_W-1:0] pa, pb;

   always_comb begin
      idx      = {above_left_ff, above, s1_ff.cur, s1_ff.left};
      n        = s1_ff.emit ? seg_count(idx) : 2'd0;
      out_free = !rsp_valid_ff || !rsp_stall;
      last_seg = seg_sel_ff || (n == 2'd1);
      seg_fire = s1_valid_ff && (n != 2'd0) && out_free;
      s1_done  = s1_valid_ff && ((n == 2'd0) || (seg_fire && last_seg));
      ready    = !s1_valid_ff || s1_done;
      pts      = seg_pts(idx, seg_sel_ff);
      pa       = point_of(pts.a, s1_ff.x_base, s1_ff.y_base, s1_ff.size);
      pb       = point_of(pts.b, s1_ff.x_base, s1_ff.y_base, s1_ff.size);
   end

   always_comb begin
      s1_valid_in  = load ? 1'b1 : (s1_done ? 1'b0 : s1_valid_ff);
      seg_sel_in   = seg_fire ? !last_seg : seg_sel_ff;
      rsp_valid_in = seg_fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         seg_sel_ff    <= 1'b0;
         above_left_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         seg_sel_ff   <= seg_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_done) begin
            above_left_ff <= above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= grid_cell;
      end
      if (seg_fire) begin
         xs_ff   <= pa[2*COORD_W-1:COORD_W];
         ys_ff   <= pa[COORD_W-1:0];
         xe_ff   <= pb[2*COORD_W-1:COORD_W];
         ye_ff   <= pb[COORD_W-1:0];
         last_ff <= last_seg;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_start = xs_ff;
   assign rsp_y_start = ys_ff;
   assign rsp_x_end   = xe_ff;
   assign rsp_y_end   = ye_ff;
   assign rsp_last    = last_ff;

   a_sel_needs_item: assert property (@(posedge clock) disable iff (reset)
      seg_sel_ff |-> s1_valid_ff)
      else $error("second segment pending with no cell held");

   a_sel_two_seg: assert property (@(posedge clock) disable iff (reset)
      seg_sel_ff |-> (idx == 4'd5 || idx == 4'd10))
      else $error("second segment pending on a single segment case");

   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      (seg_fire && !last_seg) |=> (s1_valid_ff && seg_sel_ff))
      else $error("cell released before its second segment");

endmodule

// ===== hdl/marching_squares_contour_stream.sv =====
// Top level of the marching squares contour stream: registers, raster position.
// Depends on mscs_pkg, mscs_line_buf and mscs_seg_emit.
// A sample word is registered into the segment stage, its segment words on rsp. Throughput:
//   one sample word per cycle; a cell with segments holds req while rsp stalls, and a saddle
//   cell holds it for its second segment: one output register carries one segment per cycle.
// Reset: synchronous, active high; registers to defaults, position to column 0, row 0.
module marching_squares_contour_stream
   import mscs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // sample words in
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_sample,
   input  logic                req_frame_start,
   // segment words out
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COORD_W-1:0]  rsp_x_start,
   output logic [COORD_W-1:0]  rsp_y_start,
   output logic [COORD_W-1:0]  rsp_x_end,
   output logic [COORD_W-1:0]  rsp_y_end,
   output logic                rsp_last,
   // register writes
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   // configuration
   logic signed [15:0] level_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [10:0]        cols_ff;

   // raster position and the bit to the left
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             left_ff;

   logic             accept, ready, cur, above;
   logic [COL_W-1:0] col_now;
   logic [ROW_W-1:0] row_now;
   logic [SIZE_W-1:0] s_eff;
   logic [CNT_W-1:0]  cols_eff;
   logic [CNT_W-1:0]  col_next;
   logic [COL_W+SIZE_W-1:0] x_prod;
   logic [ROW_W+SIZE_W-1:0] y_prod;
   cell_type          grid_cell;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_RESET;
         size_ff  <= SIZE_RESET;
         cols_ff  <= COLS_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEVEL:   level_ff <= $signed(csr_wdata);
            CSR_SIZE:    size_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_COLUMNS: cols_ff  <= csr_wdata[10:0];
            default:     ;
         endcase
      end
   end

   // clamp cell size to 1..16 and row width to 2..MAX_COLUMNS
   always_comb begin
      if (size_ff == '0) begin
         s_eff = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(16)) begin
         s_eff = SIZE_W'(16);
      end else begin
         s_eff = size_ff;
      end
      if (CNT_W'(cols_ff) < CNT_W'(2)) begin
         cols_eff = CNT_W'(2);
      end else if (CNT_W'(cols_ff) > CNT_W'(MAX_COLUMNS)) begin
         cols_eff = CNT_W'(MAX_COLUMNS);
      end else begin
         cols_eff = CNT_W'(cols_ff);
      end
   end

   // frame start pulls the sample to the top-left corner
   always_comb begin
      col_now  = req_frame_start ? '0 : col_ff;
      row_now  = req_frame_start ? '0 : row_ff;
      col_next = CNT_W'(col_now) + CNT_W'(1);
      if (col_next >= cols_eff) begin
         col_in = '0;
         row_in = (row_now == ROW_W'(MAX_ROWS - 1)) ? '0 : row_now + ROW_W'(1);
      end else begin
         col_in = COL_W'(col_next);
         row_in = row_now;
      end
   end

   // strict signed compare against the contour level
   assign cur = (req_sample > level_ff);

   // pixel origin of the cell whose bottom-right corner this sample is
   always_comb begin
      x_prod   = (COL_W+SIZE_W)'(col_now - COL_W'(1)) * (COL_W+SIZE_W)'(s_eff);
      y_prod   = (ROW_W+SIZE_W)'(row_now - ROW_W'(1)) * (ROW_W+SIZE_W)'(s_eff);
      grid_cell.emit   = (col_now != '0) && (row_now != '0);
      grid_cell.cur    = cur;
      grid_cell.left   = left_ff;
      grid_cell.x_base = COORD_W'(x_prod);
      grid_cell.y_base = COORD_W'(y_prod);
      grid_cell.size   = s_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= 1'b0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         left_ff <= cur;
      end
   end

   mscs_line_buf u_line_buf (
      .clock     (clock),
      .access    (accept),
      .addr      (col_now),
      .wr_bit    (cur),
      .rd_bit_ff (above)
   );

   mscs_seg_emit u_seg_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .grid_cell   (grid_cell),
      .above       (above),
      .ready       (ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_x_start (rsp_x_start),
      .rsp_y_start (rsp_y_start),
      .rsp_x_end   (rsp_x_end),
      .rsp_y_end   (rsp_y_end),
      .rsp_last    (rsp_last)
   );

endmodule
